[rtl/core/line_keyword_command_recognizer_macros.svh]
// ----------------------------------------------------------------------------
// Line keyword command recognizer - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef LINE_KEYWORD_COMMAND_RECOGNIZER_MACROS_SVH
`define LINE_KEYWORD_COMMAND_RECOGNIZER_MACROS_SVH

// Same-cycle implication
`define LKCR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LKCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lkcr_pkg.sv]
// ----------------------------------------------------------------------------
// lkcr_pkg
// Types, codes and constants of the line keyword command recognizer.
// ----------------------------------------------------------------------------
package lkcr_pkg;

  // Line buffer size including the terminator slot
  localparam int LINE_BYTES_DEF = 24;
  // Width of the reported line length
  localparam int OUT_LEN_W = 5;
  // Longest keyword; only this many leading characters are ever compared
  localparam int KW_LEN = 6;
  localparam int KW_IDX_W = $clog2(KW_LEN);
  localparam int STOP_LEN = 4;
  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // Commands
  localparam logic [1:0] CMD_BYTE      = 2'd0;
  localparam logic [1:0] CMD_RD_STATUS = 2'd1;
  localparam logic [1:0] CMD_RD_STOP   = 2'd2;

  // Match codes
  localparam logic [1:0] KW_NONE   = 2'd0;
  localparam logic [1:0] KW_STATUS = 2'd1;
  localparam logic [1:0] KW_STOP   = 2'd2;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [7:0] KW_STATUS_CHARS [KW_LEN] =
    '{8'h53, 8'h54, 8'h41, 8'h54, 8'h55, 8'h53};   // S T A T U S
  localparam logic [7:0] KW_STOP_CHARS [STOP_LEN] =
    '{8'h53, 8'h54, 8'h4F, 8'h50};                 // S T O P

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       was_pending;
    logic       status_pending;
    logic       stop_pending;
    logic [1:0] matched_keyword;
    logic [4:0] line_length;
  } out_item_t;

  // Classified item kinds
  typedef enum logic [2:0] {
    KIND_CHAR,
    KIND_LINE_END,
    KIND_ABORT,
    KIND_RD_STATUS,
    KIND_RD_STOP,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } qent_t;

  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qpush_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[rtl/core/lkcr_front.sv]
// ----------------------------------------------------------------------------
// lkcr_front
// Accepts items, folds case and classifies them for the back end.
// ----------------------------------------------------------------------------
module lkcr_front (
  input  lkcr_pkg::in_item_t in_item,
  input  logic               in_valid,
  input  lkcr_pkg::qstat_t   q_stat,
  output logic               in_stall,
  output lkcr_pkg::qpush_t   q_push
);

  logic [7:0] folded;
  logic       is_word;

  // Upper-case fold and character class
  always_comb begin
    folded = in_item.rx_byte;
    if (in_item.rx_byte >= lkcr_pkg::CH_LO_A && in_item.rx_byte <= lkcr_pkg::CH_LO_Z) begin
      folded = in_item.rx_byte - lkcr_pkg::CASE_OFS;
    end
    is_word = (folded >= lkcr_pkg::CH_UP_A && folded <= lkcr_pkg::CH_UP_Z) ||
              (folded >= lkcr_pkg::CH_0 && folded <= lkcr_pkg::CH_9) ||
              (folded == lkcr_pkg::CH_USCORE);
  end

  // Item kind
  always_comb begin
    q_push.ent.ch = folded;
    unique case (in_item.cmd)
      lkcr_pkg::CMD_BYTE: begin
        if (in_item.rx_byte == lkcr_pkg::CH_CR || in_item.rx_byte == lkcr_pkg::CH_LF) begin
          q_push.ent.kind = lkcr_pkg::KIND_LINE_END;
        end else if (is_word) begin
          q_push.ent.kind = lkcr_pkg::KIND_CHAR;
        end else begin
          q_push.ent.kind = lkcr_pkg::KIND_ABORT;
        end
      end
      lkcr_pkg::CMD_RD_STATUS: q_push.ent.kind = lkcr_pkg::KIND_RD_STATUS;
      lkcr_pkg::CMD_RD_STOP:   q_push.ent.kind = lkcr_pkg::KIND_RD_STOP;
      default:                 q_push.ent.kind = lkcr_pkg::KIND_NOP;
    endcase
  end

  assign in_stall     = q_stat.full;
  assign q_push.valid = in_valid && !q_stat.full;

endmodule

[rtl/core/lkcr_queue.sv]
// ----------------------------------------------------------------------------
// lkcr_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module lkcr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  lkcr_pkg::qpush_t  q_push,
  input  logic              q_pop,
  output lkcr_pkg::qent_t   q_head,
  output lkcr_pkg::qstat_t  q_stat
);

  localparam int PTR_W = (lkcr_pkg::Q_DEPTH > 1) ? $clog2(lkcr_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(lkcr_pkg::Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(lkcr_pkg::Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(lkcr_pkg::Q_DEPTH);

  lkcr_pkg::qent_t  slot_r [lkcr_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign do_push = q_push.valid && (cnt_r != FULL_CNT);
  assign do_pop  = q_pop && (cnt_r != '0);

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_push.ent;
    end
  end

  assign q_head       = slot_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);

endmodule

[rtl/core/lkcr_back.sv]
// ----------------------------------------------------------------------------
// lkcr_back
// Carries out queued items: line gathering, keyword match, flags, result.
// ----------------------------------------------------------------------------
module lkcr_back #(
  parameter int LINE_BYTES = lkcr_pkg::LINE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lkcr_pkg::qent_t     q_head,
  input  lkcr_pkg::qstat_t    q_stat,
  output logic                q_pop,
  input  logic                out_stall,
  output logic                out_valid,
  output lkcr_pkg::out_item_t out_item
);

  localparam int CNT_W = $clog2(LINE_BYTES);
  localparam logic [CNT_W-1:0] LINE_MAX = CNT_W'(LINE_BYTES - 1);
  localparam logic [CNT_W-1:0] KW_LEN_C = CNT_W'(lkcr_pkg::KW_LEN);
  localparam logic [CNT_W-1:0] STOP_LEN_C = CNT_W'(lkcr_pkg::STOP_LEN);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               status_r, status_nxt;
  logic               stop_r, stop_nxt;
  logic               out_valid_r, out_valid_nxt;
  lkcr_pkg::out_item_t out_item_r, out_item_nxt;
  logic [7:0]         store_r [lkcr_pkg::KW_LEN];
  logic               store_we;
  logic               was;
  logic [1:0]         matched;
  logic               eq_status, eq_stop;

  // Fire when an item waits and the output register is free or draining
  assign q_pop = !q_stat.empty && (!out_valid_r || !out_stall);

  // Keyword compare over the leading characters
  always_comb begin
    eq_status = (cnt_r == KW_LEN_C);
    for (int i = 0; i < lkcr_pkg::KW_LEN; i++) begin
      if (store_r[i] != lkcr_pkg::KW_STATUS_CHARS[i]) eq_status = 1'b0;
    end
    eq_stop = (cnt_r == STOP_LEN_C);
    for (int i = 0; i < lkcr_pkg::STOP_LEN; i++) begin
      if (store_r[i] != lkcr_pkg::KW_STOP_CHARS[i]) eq_stop = 1'b0;
    end
  end

  // Item execution
  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    stop_nxt   = stop_r;
    store_we   = 1'b0;
    was        = 1'b0;
    matched    = lkcr_pkg::KW_NONE;
    unique case (q_head.kind)
      lkcr_pkg::KIND_CHAR: begin
        if (cnt_r < LINE_MAX) begin
          store_we = (cnt_r < KW_LEN_C);
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          cnt_nxt = '0;
        end
      end
      lkcr_pkg::KIND_LINE_END: begin
        if (cnt_r != '0) begin
          if (eq_status) begin
            status_nxt = 1'b1;
            matched    = lkcr_pkg::KW_STATUS;
          end else if (eq_stop) begin
            stop_nxt = 1'b1;
            matched  = lkcr_pkg::KW_STOP;
          end
          cnt_nxt = '0;
        end
      end
      lkcr_pkg::KIND_ABORT: cnt_nxt = '0;
      lkcr_pkg::KIND_RD_STATUS: begin
        was        = status_r;
        status_nxt = 1'b0;
      end
      lkcr_pkg::KIND_RD_STOP: begin
        was      = stop_r;
        stop_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (q_pop) begin
      out_valid_nxt                = 1'b1;
      out_item_nxt.was_pending     = was;
      out_item_nxt.status_pending  = status_nxt;
      out_item_nxt.stop_pending    = stop_nxt;
      out_item_nxt.matched_keyword = matched;
      out_item_nxt.line_length     = lkcr_pkg::OUT_LEN_W'(cnt_nxt);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      status_r    <= 1'b0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      cnt_r       <= cnt_nxt;
      status_r    <= status_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (q_pop && store_we) begin
      store_r[cnt_r[lkcr_pkg::KW_IDX_W-1:0]] <= q_head.ch;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/core/line_keyword_command_recognizer.sv]
// ----------------------------------------------------------------------------
// line_keyword_command_recognizer
// Gathers received bytes into text lines and flags STATUS / STOP commands.
// ----------------------------------------------------------------------------
// Channel  | Ports                          | Moves
// ---------+--------------------------------+-------------------------------
// input    | in_valid, in_stall, in_item    | byte or read-and-clear item
// output   | out_valid, out_stall, out_item | one result per input item
//
// One item per cycle sustained while out_stall is low. An accepted item
// passes through a queue slot, then execution into the result register,
// where out_valid rises and the result can be taken.
// The back end retires at most one item per cycle from the two-entry queue.
// Synchronous active-low reset clears line count, flags, queue and out_valid.
// in_stall rises only when the queue is full; out_stall holds the result.
// ----------------------------------------------------------------------------
`include "line_keyword_command_recognizer_macros.svh"

module line_keyword_command_recognizer #(
  parameter int LINE_BYTES = lkcr_pkg::LINE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lkcr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lkcr_pkg::out_item_t out_item
);

  lkcr_pkg::qpush_t q_push;
  lkcr_pkg::qstat_t q_stat;
  lkcr_pkg::qent_t  q_head;
  logic             q_pop;
  logic             res_match;
  logic             res_status;
  logic             res_read;

  // Classifier
  lkcr_front u_front (
    .in_item  (in_item),
    .in_valid (in_valid),
    .q_stat   (q_stat),
    .in_stall (in_stall),
    .q_push   (q_push)
  );

  // Decoupling queue
  lkcr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  // Executor and result register
  lkcr_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Result classes seen by the checks
  assign res_match  = out_valid && (out_item.matched_keyword != lkcr_pkg::KW_NONE);
  assign res_status = out_valid && (out_item.matched_keyword == lkcr_pkg::KW_STATUS);
  assign res_read   = out_valid && out_item.was_pending;

  // Checks
  `LKCR_ASSERT_IMP(a_match_clears_line, res_match, out_item.line_length == '0, "line open on match")
  `LKCR_ASSERT_IMP(a_status_match_sets_flag, res_status, out_item.status_pending, "no status flag")
  `LKCR_ASSERT_IMP(a_read_has_no_match, res_read, !res_match, "read reported a match")
  `LKCR_ASSERT_NEXT(a_queue_drains, !q_stat.empty && !out_stall, out_valid, "queued item stuck")

endmodule
